@@ rtl/core/dfd_pkg.sv @@
// Shared types and constants for the DSHOT frame decoder.
`timescale 1ns / 1ps

package dfd_pkg;

   // Frame layout
   localparam int FRAME_BITS  = 16;
   localparam int COUNT_W     = 6;
   localparam int RAW_W       = 11;
   localparam int NIBBLE_W    = 4;
   localparam int WIDTH_W     = 16;
   localparam int THROTTLE_W  = 15;

   // Throttle scaling: product of scale and raw, divided by 2047
   localparam int PROD_W      = THROTTLE_W + RAW_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int DIV_SHIFT   = 11;
   localparam int RAW_FULL    = 2047;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_PULSE_MIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_PULSE_MAX = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THROTTLE_SCALE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_ON_ERROR   = 3'd4;

   // Request item types
   localparam logic REQ_PULSE     = 1'b0;
   localparam logic REQ_FRAME_END = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [WIDTH_W-1:0]   pulse_width;
   } req_item_type;

   typedef struct packed {
      logic [THROTTLE_W-1:0] throttle;
      logic                  telemetry_request;
      logic                  frame_ok;
   } rsp_item_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]    bit_threshold;
      logic [WIDTH_W-1:0]    first_pulse_min;
      logic [WIDTH_W-1:0]    first_pulse_max;
      logic [THROTTLE_W-1:0] throttle_scale;
      logic                  zero_on_error;
   } cfg_type;

   // One classified frame handed from front to back
   typedef struct packed {
      logic             ok;
      logic             telemetry;
      logic [RAW_W-1:0] raw;
   } job_type;

endpackage

@@ rtl/core/dfd_queue.sv @@
// Small job queue between the frame front end and the scaling back end.
`timescale 1ns / 1ps

module dfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dfd_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output dfd_pkg::job_type  pop_data
);

   dfd_pkg::job_type                    mem_ff [dfd_pkg::QUEUE_DEPTH];
   logic [dfd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dfd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dfd_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full     = (count_ff == dfd_pkg::QUEUE_CNT_W'(dfd_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/dfd_front.sv @@
// Front end: shifts in pulse bits, checks the frame at frame end, queues a job.
`timescale 1ns / 1ps

module dfd_front #(
   parameter int MAX_PULSES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dfd_pkg::cfg_type      cfg,
   input  logic                  req_push,
   input  dfd_pkg::req_item_type req_data,
   input  logic                  job_full,
   output logic                  job_push,
   output dfd_pkg::job_type      job_data
);

   logic [dfd_pkg::FRAME_BITS-1:0] bit_shift_ff, bit_shift_in;
   logic [dfd_pkg::COUNT_W-1:0]    pulse_count_ff, pulse_count_in;
   logic                           first_in_range_ff, first_in_range_in;
   logic                           last_telemetry_ff, last_telemetry_in;
   logic                           accept;
   logic                           pulse_bit;
   logic                           width_in_range;
   logic [dfd_pkg::NIBBLE_W-1:0]   crc_calc;
   logic                           frame_ok;

   assign accept = req_push && !job_full;

   // Per-pulse classification
   assign pulse_bit      = (req_data.pulse_width > cfg.bit_threshold);
   assign width_in_range = (req_data.pulse_width >= cfg.first_pulse_min) &&
                           (req_data.pulse_width <= cfg.first_pulse_max);

   // Frame check: count, first pulse, XOR of the three data nibbles
   assign crc_calc = bit_shift_ff[15:12] ^ bit_shift_ff[11:8] ^ bit_shift_ff[7:4];
   assign frame_ok = (pulse_count_ff == dfd_pkg::COUNT_W'(dfd_pkg::FRAME_BITS)) &&
                     first_in_range_ff && (crc_calc == bit_shift_ff[3:0]);

   // Job for the back end
   always_comb begin
      job_data.ok        = frame_ok;
      job_data.telemetry = frame_ok ? bit_shift_ff[4] : last_telemetry_ff;
      job_data.raw       = frame_ok ? bit_shift_ff[15:5] : '0;
   end
   assign job_push = accept && (req_data.req_type == dfd_pkg::REQ_FRAME_END) &&
                     (frame_ok || cfg.zero_on_error);

   // Frame state update
   always_comb begin
      bit_shift_in      = bit_shift_ff;
      pulse_count_in    = pulse_count_ff;
      first_in_range_in = first_in_range_ff;
      last_telemetry_in = last_telemetry_ff;
      if (accept) begin
         unique case (req_data.req_type)
            dfd_pkg::REQ_PULSE: begin
               if (pulse_count_ff < dfd_pkg::COUNT_W'(MAX_PULSES)) begin
                  if (pulse_count_ff == '0) begin
                     first_in_range_in = width_in_range;
                  end
                  bit_shift_in   = {bit_shift_ff[dfd_pkg::FRAME_BITS-2:0], pulse_bit};
                  pulse_count_in = pulse_count_ff + 1'b1;
               end
            end
            dfd_pkg::REQ_FRAME_END: begin
               if (frame_ok) begin
                  last_telemetry_in = bit_shift_ff[4];
               end
               bit_shift_in      = '0;
               pulse_count_in    = '0;
               first_in_range_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_shift_ff      <= '0;
         pulse_count_ff    <= '0;
         first_in_range_ff <= 1'b0;
         last_telemetry_ff <= 1'b0;
      end else begin
         bit_shift_ff      <= bit_shift_in;
         pulse_count_ff    <= pulse_count_in;
         first_in_range_ff <= first_in_range_in;
         last_telemetry_ff <= last_telemetry_in;
      end
   end

endmodule

@@ rtl/core/dfd_back.sv @@
// Back end: scales raw throttle by throttle_scale / 2047 in a three-stage pipeline.
`timescale 1ns / 1ps

module dfd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dfd_pkg::cfg_type      cfg,
   input  logic                  job_empty,
   input  dfd_pkg::job_type      job_data,
   output logic                  job_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output dfd_pkg::rsp_item_type rsp_data
);

   // Stage 1: product
   logic                          s1_valid_ff;
   logic [dfd_pkg::PROD_W-1:0]    s1_prod_ff, s1_prod_in;
   logic                          s1_ok_ff;
   logic                          s1_tel_ff;
   // Stage 2: quotient estimate
   logic                          s2_valid_ff;
   logic [dfd_pkg::PROD_W-1:0]    s2_prod_ff;
   logic [dfd_pkg::THROTTLE_W-1:0] s2_quot_ff, s2_quot_in;
   logic                          s2_ok_ff;
   logic                          s2_tel_ff;
   // Stage 3: corrected quotient, held as the result register
   logic                          s3_valid_ff;
   logic [dfd_pkg::THROTTLE_W-1:0] s3_quot_ff, s3_quot_in;
   logic                          s3_ok_ff;
   logic                          s3_tel_ff;

   logic                          advance;
   logic [dfd_pkg::SUM_W-1:0]     est_sum;
   logic [dfd_pkg::SUM_W-1:0]     remainder;

   // Whole pipeline moves unless a result is stuck at the output
   assign advance   = !s3_valid_ff || rsp_pop;
   assign job_pop   = advance && !job_empty;
   assign rsp_empty = !s3_valid_ff;

   always_comb begin
      rsp_data.throttle          = s3_quot_ff;
      rsp_data.telemetry_request = s3_tel_ff;
      rsp_data.frame_ok          = s3_ok_ff;
   end

   // 15x11 multiply
   assign s1_prod_in = dfd_pkg::PROD_W'(cfg.throttle_scale) * dfd_pkg::PROD_W'(job_data.raw);

   // x/2047 ~ (x + x/2^11 + x/2^22) / 2^11, low by at most one
   assign est_sum = dfd_pkg::SUM_W'(s1_prod_ff) +
                    dfd_pkg::SUM_W'(s1_prod_ff >> dfd_pkg::DIV_SHIFT) +
                    dfd_pkg::SUM_W'(s1_prod_ff >> (2 * dfd_pkg::DIV_SHIFT));
   assign s2_quot_in = dfd_pkg::THROTTLE_W'(est_sum >> dfd_pkg::DIV_SHIFT);

   // Remainder p - 2047*q, one correction step
   assign remainder = dfd_pkg::SUM_W'(s2_prod_ff) + dfd_pkg::SUM_W'(s2_quot_ff) -
                      (dfd_pkg::SUM_W'(s2_quot_ff) << dfd_pkg::DIV_SHIFT);
   assign s3_quot_in = (remainder >= dfd_pkg::SUM_W'(dfd_pkg::RAW_FULL)) ?
                       s2_quot_ff + 1'b1 : s2_quot_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= !job_empty;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= s1_prod_in;
         s1_ok_ff   <= job_data.ok;
         s1_tel_ff  <= job_data.telemetry;
         s2_prod_ff <= s1_prod_ff;
         s2_quot_ff <= s2_quot_in;
         s2_ok_ff   <= s1_ok_ff;
         s2_tel_ff  <= s1_tel_ff;
         s3_quot_ff <= s3_quot_in;
         s3_ok_ff   <= s2_ok_ff;
         s3_tel_ff  <= s2_tel_ff;
      end
   end

endmodule

@@ rtl/core/dshot_frame_decoder.sv @@
// DSHOT frame decoder top level: config registers, front end, job queue, back end.
// A frame-end transaction's result reaches the rsp_ ports through the job queue, written at
// the accepting edge, and then the three-stage pipeline, which holds while a result waits.
// Throughput: one request transaction per cycle while req_full is low; req_full rises only
// when the four-entry job queue is full, which happens when results are not popped.
// Reset clears the frame state, queue and pipeline and loads the register defaults.
`timescale 1ns / 1ps

module dshot_frame_decoder #(
   parameter int MAX_PULSES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  dfd_pkg::req_item_type               req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output dfd_pkg::rsp_item_type               rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dfd_pkg::WIDTH_W-1:0]         csr_data
);

   dfd_pkg::cfg_type cfg_ff, cfg_in;
   logic             job_push;
   logic             job_full;
   logic             job_pop;
   logic             job_empty;
   dfd_pkg::job_type job_wr_data;
   dfd_pkg::job_type job_rd_data;

   // Register writes, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dfd_pkg::CSR_BIT_THRESHOLD:   cfg_in.bit_threshold   = csr_data;
            dfd_pkg::CSR_FIRST_PULSE_MIN: cfg_in.first_pulse_min = csr_data;
            dfd_pkg::CSR_FIRST_PULSE_MAX: cfg_in.first_pulse_max = csr_data;
            dfd_pkg::CSR_THROTTLE_SCALE:
               cfg_in.throttle_scale = csr_data[dfd_pkg::THROTTLE_W-1:0];
            dfd_pkg::CSR_ZERO_ON_ERROR:   cfg_in.zero_on_error   = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_threshold   <= '0;
         cfg_ff.first_pulse_min <= '0;
         cfg_ff.first_pulse_max <= '1;
         cfg_ff.throttle_scale  <= dfd_pkg::THROTTLE_W'(dfd_pkg::RAW_FULL);
         cfg_ff.zero_on_error   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = job_full;

   dfd_front #(
      .MAX_PULSES (MAX_PULSES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_wr_data)
   );

   dfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr_data),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_rd_data)
   );

   dfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_rd_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/dshot_frame_decoder_tb.sv @@
// Self-checking testbench for the DSHOT frame decoder: directed frames, then random phases.
`timescale 1ns / 1ps

module dshot_frame_decoder_tb;

   localparam int MAX_PULSES   = 32;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 16;
   localparam int TIMEOUT_NS   = 5_000_000;
   localparam logic [dfd_pkg::WIDTH_W-1:0] WIDTH_MAX = 16'hffff;

   // One row of the directed table; a typed result replaces the decoded one
   typedef struct {
      dfd_pkg::req_item_type item;
      bit                    typed;
      dfd_pkg::rsp_item_type rsp;
   } stim_row_type;

   localparam dfd_pkg::req_item_type FULL_PULSE = '{dfd_pkg::REQ_PULSE, WIDTH_MAX};
   localparam dfd_pkg::req_item_type ZERO_PULSE = '{dfd_pkg::REQ_PULSE, 16'd0};
   localparam dfd_pkg::req_item_type FRAME_END  = '{dfd_pkg::REQ_FRAME_END, 16'd0};
   localparam dfd_pkg::rsp_item_type NO_RSP     = '0;
   localparam int                    DIR_ROWS   = 21;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   dfd_pkg::req_item_type           req_data = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   dfd_pkg::rsp_item_type           rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [dfd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dfd_pkg::WIDTH_W-1:0]     csr_data = '0;

   // Decoder state as predicted by the testbench
   dfd_pkg::cfg_type                model_cfg;
   logic [dfd_pkg::FRAME_BITS-1:0]  frame_bits;
   int                              pulses_seen;
   logic                            first_ok;
   logic                            last_tel;

   dfd_pkg::rsp_item_type           pending_rsp[$];
   int                              fail_count = 0;
   int                              phase_items;
   bit                              idle_on = 1'b1;

   // Empty frame, single short pulse, all-ones frame at full scale, empty frame again
   stim_row_type dir_table [DIR_ROWS] = '{
      '{FRAME_END,  1'b1, '{15'd0, 1'b0, 1'b0}},
      '{ZERO_PULSE, 1'b0, NO_RSP},
      '{FRAME_END,  1'b1, '{15'd0, 1'b0, 1'b0}},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FULL_PULSE, 1'b0, NO_RSP}, '{FULL_PULSE, 1'b0, NO_RSP},
      '{FRAME_END,  1'b1, '{15'd2047, 1'b1, 1'b1}},
      '{FRAME_END,  1'b1, '{15'd0, 1'b1, 1'b0}}
   };

   dshot_frame_decoder #(
      .MAX_PULSES(MAX_PULSES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Decode one accepted event; returns 1 when the frame end yields a result
   function automatic bit decode_event(input dfd_pkg::req_item_type item,
                                       output dfd_pkg::rsp_item_type res);
      logic [dfd_pkg::NIBBLE_W-1:0] crc_calc;
      logic [dfd_pkg::RAW_W-1:0]    raw;
      logic [dfd_pkg::PROD_W-1:0]   prod;
      bit                           frame_good;
      bit                           emitted;
      res = '0;
      emitted = 1'b0;
      if (item.req_type == dfd_pkg::REQ_PULSE) begin
         if (pulses_seen < MAX_PULSES) begin
            if (pulses_seen == 0)
               first_ok = item.pulse_width >= model_cfg.first_pulse_min &&
                          item.pulse_width <= model_cfg.first_pulse_max;
            frame_bits = {frame_bits[dfd_pkg::FRAME_BITS-2:0],
                          item.pulse_width > model_cfg.bit_threshold};
            pulses_seen++;
         end
      end else begin
         crc_calc = frame_bits[15:12] ^ frame_bits[11:8] ^ frame_bits[7:4];
         frame_good = pulses_seen == dfd_pkg::FRAME_BITS && first_ok &&
                      crc_calc == frame_bits[3:0];
         if (frame_good) begin
            raw = frame_bits[15:5];
            prod = dfd_pkg::PROD_W'(model_cfg.throttle_scale) * dfd_pkg::PROD_W'(raw);
            last_tel = frame_bits[4];
            res.throttle = dfd_pkg::THROTTLE_W'(prod / dfd_pkg::RAW_FULL);
            res.telemetry_request = last_tel;
            res.frame_ok = 1'b1;
            emitted = 1'b1;
         end else if (model_cfg.zero_on_error) begin
            res.telemetry_request = last_tel;
            emitted = 1'b1;
         end
         frame_bits = '0;
         pulses_seen = 0;
         first_ok = 1'b0;
      end
      return emitted;
   endfunction

   // Drive one request transaction, called and returning at a falling edge
   task automatic send_req(input dfd_pkg::req_item_type item, input bit typed,
                           input dfd_pkg::rsp_item_type typed_rsp);
      dfd_pkg::rsp_item_type res;
      bit                    counts;
      if (idle_on && $urandom_range(5, 0) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(14, 1)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      // pulses past saturation do nothing
      counts = item.req_type == dfd_pkg::REQ_FRAME_END || pulses_seen < MAX_PULSES;
      if (decode_event(item, res))
         pending_rsp.push_back(typed ? typed_rsp : res);
      else if (typed)
         pending_rsp.push_back(typed_rsp);
      if (counts)
         phase_items++;
      @(negedge clock);
   endtask

   task automatic send_event(input logic kind, input logic [dfd_pkg::WIDTH_W-1:0] width);
      dfd_pkg::req_item_type item;
      item.req_type = kind;
      item.pulse_width = width;
      send_req(item, 1'b0, NO_RSP);
   endtask

   // Register write, called and returning at a falling edge; caller lowers valid
   task automatic write_csr(input logic [dfd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dfd_pkg::WIDTH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dfd_pkg::CSR_BIT_THRESHOLD:   model_cfg.bit_threshold   = value;
         dfd_pkg::CSR_FIRST_PULSE_MIN: model_cfg.first_pulse_min = value;
         dfd_pkg::CSR_FIRST_PULSE_MAX: model_cfg.first_pulse_max = value;
         dfd_pkg::CSR_THROTTLE_SCALE:
            model_cfg.throttle_scale = value[dfd_pkg::THROTTLE_W-1:0];
         dfd_pkg::CSR_ZERO_ON_ERROR:   model_cfg.zero_on_error   = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Let every expected result arrive, then let frames without results flush
   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Register settings per phase: extremes first, then random
   task automatic configure_phase(input int phase);
      logic [dfd_pkg::WIDTH_W-1:0] thr, lo, hi, scale;
      logic                        zoe;
      thr   = dfd_pkg::WIDTH_W'($urandom_range(65535, 0));
      lo    = dfd_pkg::WIDTH_W'($urandom_range(32767, 0));
      hi    = dfd_pkg::WIDTH_W'($urandom_range(65535, lo));
      scale = dfd_pkg::WIDTH_W'($urandom_range(65535, 0));
      zoe   = 1'($urandom_range(1, 0));
      case (phase)
         0: begin
            thr = '0;   lo = '0; hi = WIDTH_MAX; scale = 16'h7fff; zoe = 1'b1;
         end
         1: begin
            thr = WIDTH_MAX; lo = '0; hi = WIDTH_MAX; scale = 16'h8000; zoe = 1'b0;
         end
         2: begin
            // min above max: nothing passes
            lo = WIDTH_MAX; hi = '0; zoe = 1'b1;
         end
         default: ;
      endcase
      write_csr(dfd_pkg::CSR_BIT_THRESHOLD, thr);
      write_csr(dfd_pkg::CSR_FIRST_PULSE_MIN, lo);
      write_csr(dfd_pkg::CSR_FIRST_PULSE_MAX, hi);
      write_csr(dfd_pkg::CSR_THROTTLE_SCALE, scale);
      write_csr(dfd_pkg::CSR_ZERO_ON_ERROR, {15'($urandom_range(32767, 0)), zoe});
      // indexes past the register list are ignored
      write_csr(dfd_pkg::CSR_INDEX_W'(dfd_pkg::CSR_ZERO_ON_ERROR + 1 + $urandom_range(2, 0)),
                dfd_pkg::WIDTH_W'($urandom_range(65535, 0)));
      csr_valid <= 1'b0;
   endtask

   // Width that reads as the given bit, inside the first-pulse window if asked and possible
   function automatic logic [dfd_pkg::WIDTH_W-1:0] pick_width(input logic one, input bit first);
      int lo, hi;
      lo = one ? int'(model_cfg.bit_threshold) + 1 : 0;
      hi = one ? 65535 : int'(model_cfg.bit_threshold);
      if (first) begin
         if (lo < int'(model_cfg.first_pulse_min)) lo = int'(model_cfg.first_pulse_min);
         if (hi > int'(model_cfg.first_pulse_max)) hi = int'(model_cfg.first_pulse_max);
         if (lo > hi) begin
            lo = one ? int'(model_cfg.bit_threshold) + 1 : 0;
            hi = one ? 65535 : int'(model_cfg.bit_threshold);
         end
      end
      case ($urandom_range(7, 0))
         0: return dfd_pkg::WIDTH_W'(lo);
         1: return dfd_pkg::WIDTH_W'(hi);
         default: return dfd_pkg::WIDTH_W'($urandom_range(hi, lo));
      endcase
   endfunction

   // Mostly well-formed frames; the rest bad CRC, bad first pulse, random counts, empty
   task automatic send_random_frame();
      int                             kind;
      int                             n_pulses;
      logic [dfd_pkg::FRAME_BITS-1:0] word;
      logic [dfd_pkg::WIDTH_W-1:0]    width;
      kind = $urandom_range(15, 0);
      word[15:5] = 11'($urandom_range(2047, 0));
      case ($urandom_range(7, 0))
         0: word[15:5] = '0;
         1: word[15:5] = '1;
         default: ;
      endcase
      word[4] = 1'($urandom_range(1, 0));
      word[3:0] = word[15:12] ^ word[11:8] ^ word[7:4];
      // threshold at the top: every pulse reads zero
      if (model_cfg.bit_threshold == WIDTH_MAX)
         word = '0;
      if (kind == 11)
         word[$urandom_range(15, 0)] ^= 1'b1;
      if (kind <= 12) begin
         for (int i = 0; i < dfd_pkg::FRAME_BITS; i++) begin
            width = pick_width(word[15-i], i == 0);
            if (i == 0 && kind == 12) begin
               if (model_cfg.first_pulse_min != 0)
                  width = dfd_pkg::WIDTH_W'(
                             $urandom_range(int'(model_cfg.first_pulse_min) - 1, 0));
               else if (model_cfg.first_pulse_max != WIDTH_MAX)
                  width = dfd_pkg::WIDTH_W'(
                             $urandom_range(65535, int'(model_cfg.first_pulse_max) + 1));
            end
            send_event(dfd_pkg::REQ_PULSE, width);
         end
      end else if (kind != 15) begin
         n_pulses = kind == 13 ? $urandom_range(20, 0) : $urandom_range(45, MAX_PULSES + 1);
         repeat (n_pulses)
            send_event(dfd_pkg::REQ_PULSE, dfd_pkg::WIDTH_W'($urandom_range(65535, 0)));
      end
      send_event(dfd_pkg::REQ_FRAME_END, dfd_pkg::WIDTH_W'($urandom_range(65535, 0)));
   endtask

   // Result consumer: random stall bursts while idling is on
   initial begin : pop_driver
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(9, 0) == 0) begin
            hold = $urandom_range(13, 0);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Compare each popped transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      dfd_pkg::rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: throttle %0d telemetry_request %0d frame_ok %0d",
                   rsp_data.throttle, rsp_data.telemetry_request, rsp_data.frame_ok);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.throttle !== want.throttle) begin
               $error("throttle: expected %0d, actual %0d", want.throttle, rsp_data.throttle);
               fail_count++;
            end
            if (rsp_data.telemetry_request !== want.telemetry_request) begin
               $error("telemetry_request: expected %0d, actual %0d",
                      want.telemetry_request, rsp_data.telemetry_request);
               fail_count++;
            end
            if (rsp_data.frame_ok !== want.frame_ok) begin
               $error("frame_ok: expected %0d, actual %0d", want.frame_ok, rsp_data.frame_ok);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : main_seq
      model_cfg = '{16'd0, 16'd0, WIDTH_MAX, 15'd2047, 1'b1};
      frame_bits = '0;
      pulses_seen = 0;
      first_ok = 1'b0;
      last_tel = 1'b0;
      phase_items = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table under reset defaults
      for (int i = 0; i < DIR_ROWS; i++)
         send_req(dir_table[i].item, dir_table[i].typed, dir_table[i].rsp);
      req_push <= 1'b0;

      // random phases, last one without idling
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         configure_phase(p);
         if (p == PHASE_COUNT - 1)
            idle_on = 1'b0;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS)
            send_random_frame();
         req_push <= 1'b0;
      end

      wait_drained();
      if (pending_rsp.size() == 0 && fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/dfd_pkg.sv
rtl/core/dfd_queue.sv
rtl/core/dfd_front.sv
rtl/core/dfd_back.sv
rtl/core/dshot_frame_decoder.sv
test/dshot_frame_decoder_tb.sv
